### hw/rtl/vtp_pkg.sv
`timescale 1ns / 1ps

package vtp_pkg;

    // Default depth of the queue between the transform front and the divide back.
    localparam int QUEUE_DEPTH  = 8;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int COORD_W      = 16;
    localparam int VIEW_W       = 45;   // signed view coordinate in .12 units
    localparam int DEN_W        = 44;   // positive clamped depth in .12 units
    localparam int MAG_W        = 60;   // |v| * H
    localparam int QUO_W        = 22;   // quotient bits in 1/16 units
    localparam int REM_W        = 68;   // divider working remainder
    localparam int OFS_W        = 16;
    localparam int DEPTH_W      = 31;
    localparam int SCR_W        = 15;
    localparam int SUM_W        = 24;   // offset plus projected value before clamp

    localparam logic signed [SUM_W-1:0] SCR_MIN = -24'sd16384;
    localparam logic signed [SUM_W-1:0] SCR_MAX = 24'sd16368;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_TRANS_X,
        REG_TRANS_Y,
        REG_TRANS_Z,
        REG_PROJ,
        REG_OFFSET
    } t_reg_idx;

    typedef struct packed {
        logic                    neg;
        logic [MAG_W-1:0]        mag;
        logic signed [OFS_W-1:0] ofs;
    } t_axis;

    typedef struct packed {
        t_axis               ax_x;
        t_axis               ax_y;
        logic [DEN_W-1:0]    den;
        logic [DEPTH_W-1:0]  depth;
    } t_job;

endpackage

### hw/rtl/vtp_front.sv
`timescale 1ns / 1ps

module vtp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  logic signed [vtp_pkg::COORD_W-1:0]  i_model_x,
    input  logic signed [vtp_pkg::COORD_W-1:0]  i_model_y,
    input  logic signed [vtp_pkg::COORD_W-1:0]  i_model_z,
    output logic                                o_push,
    output vtp_pkg::t_job                       o_job
);

    localparam int VW = vtp_pkg::VIEW_W;
    localparam int DW = vtp_pkg::DEN_W;
    localparam int COORD_W_L = vtp_pkg::COORD_W;

    logic [47:0]        r_rot [3];
    logic [31:0]        r_trans [3];
    logic [15:0]        r_proj;
    logic [31:0]        r_ofs;

    logic               r1_valid;
    logic signed [31:0] r1_prod [3][3];
    logic [15:0]        r1_h;

    logic               r2_valid;
    logic signed [VW-1:0] r2_vx;
    logic signed [VW-1:0] r2_vy;
    logic [DW-1:0]      r2_d;
    logic [15:0]        r2_h;

    logic               r3_valid;
    vtp_pkg::t_job      r3_job;

    logic signed [COORD_W_L-1:0] w_m [3];

    logic signed [VW-1:0] n_v [3];
    logic [26:0]          n_near;
    logic [DW-1:0]        n_d;
    logic [DW-1:0]        n_absx;
    logic [DW-1:0]        n_absy;
    logic signed [VW-1:0] n_negx;
    logic signed [VW-1:0] n_negy;

    assign w_m[0] = i_model_x;
    assign w_m[1] = i_model_y;
    assign w_m[2] = i_model_z;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= 48'h0000_0000_1000;
            r_rot[1]   <= 48'h0000_1000_0000;
            r_rot[2]   <= 48'h1000_0000_0000;
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
            r_proj     <= 16'd256;
            r_ofs      <= '0;
        end else if (i_cfg_we) begin
            unique case (vtp_pkg::t_reg_idx'(i_cfg_index))
                vtp_pkg::REG_ROT0:    r_rot[0]   <= i_cfg_data;
                vtp_pkg::REG_ROT1:    r_rot[1]   <= i_cfg_data;
                vtp_pkg::REG_ROT2:    r_rot[2]   <= i_cfg_data;
                vtp_pkg::REG_TRANS_X: r_trans[0] <= i_cfg_data[31:0];
                vtp_pkg::REG_TRANS_Y: r_trans[1] <= i_cfg_data[31:0];
                vtp_pkg::REG_TRANS_Z: r_trans[2] <= i_cfg_data[31:0];
                vtp_pkg::REG_PROJ:    r_proj     <= i_cfg_data[15:0];
                vtp_pkg::REG_OFFSET:  r_ofs      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Stage 1: the nine rotation products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_accept;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r1_prod[i][j] <= $signed(r_rot[i][16*j +: 16]) * w_m[j];
            end
        end
        r1_h <= (r_proj == 16'd0) ? 16'd1 : r_proj;
    end

    // Stage 2: row sums plus translation, near-plane clamp of depth.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v[i] = {{(VW-32){r1_prod[i][0][31]}}, r1_prod[i][0]}
                   + {{(VW-32){r1_prod[i][1][31]}}, r1_prod[i][1]}
                   + {{(VW-32){r1_prod[i][2][31]}}, r1_prod[i][2]}
                   + {r_trans[i][31], r_trans[i], 12'b0};
        end
        n_near = (r1_h == 16'd1) ? 27'd4096 : {r1_h, 11'b0};
        if (n_v[2] > $signed({{(VW-27){1'b0}}, n_near})) begin
            n_d = n_v[2][DW-1:0];
        end else begin
            n_d = {{(DW-27){1'b0}}, n_near};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_vx <= n_v[0];
        r2_vy <= n_v[1];
        r2_d  <= n_d;
        r2_h  <= r1_h;
    end

    // Stage 3: magnitudes times H, depth to integer.
    always_comb begin
        n_negx = -r2_vx;
        n_negy = -r2_vy;
        n_absx = r2_vx[VW-1] ? n_negx[DW-1:0] : r2_vx[DW-1:0];
        n_absy = r2_vy[VW-1] ? n_negy[DW-1:0] : r2_vy[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_job.ax_x.neg <= r2_vx[VW-1];
        r3_job.ax_y.neg <= r2_vy[VW-1];
        r3_job.ax_x.mag <= n_absx * r2_h;
        r3_job.ax_y.mag <= n_absy * r2_h;
        r3_job.ax_x.ofs <= r_ofs[15:0];
        r3_job.ax_y.ofs <= r_ofs[31:16];
        r3_job.den      <= r2_d;
        r3_job.depth    <= r2_d[DW-1] ? {vtp_pkg::DEPTH_W{1'b1}} : r2_d[DW-2:12];
    end

    assign o_push = r3_valid;
    assign o_job  = r3_job;

endmodule

### hw/rtl/vtp_queue.sv
`timescale 1ns / 1ps

module vtp_queue #(
    parameter int DEPTH = vtp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_reserve,
    input  logic           i_push,
    input  vtp_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output vtp_pkg::t_job  o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vtp_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_resv;
    logic          w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    // Reservations count items in the front pipeline plus stored entries,
    // so a pushed item always finds room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_resv <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt  <= r_cnt + CW'(i_push) - CW'(w_pop);
            r_resv <= r_resv + CW'(i_reserve) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_full  = (r_resv >= CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

endmodule

### hw/rtl/vtp_back.sv
`timescale 1ns / 1ps

module vtp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  vtp_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [vtp_pkg::SCR_W-1:0]    o_screen_x,
    output logic signed [vtp_pkg::SCR_W-1:0]    o_screen_y,
    output logic [vtp_pkg::DEPTH_W-1:0]         o_view_depth
);

    localparam int QW = vtp_pkg::QUO_W;
    localparam int RW = vtp_pkg::REM_W;
    localparam int SW = vtp_pkg::SUM_W;

    logic                  w_adv;
    logic                  r_vld [QW+1];
    logic [RW-1:0]         r_rem [2][QW+1];
    logic [QW-1:0]         r_q   [2][QW+1];
    logic                  r_ovf [2][QW+1];
    logic                  r_neg [2][QW+1];
    logic signed [15:0]    r_ofs [2][QW+1];
    logic [vtp_pkg::DEN_W-1:0]   r_den [QW+1];
    logic [vtp_pkg::DEPTH_W-1:0] r_dep [QW+1];

    logic                  r_ov;
    logic signed [vtp_pkg::SCR_W-1:0] r_sx;
    logic signed [vtp_pkg::SCR_W-1:0] r_sy;
    logic [vtp_pkg::DEPTH_W-1:0]      r_dp;

    vtp_pkg::t_axis        w_in_ax [2];
    logic [RW-1:0]         w_num   [2];
    logic signed [SW-1:0]  w_scr   [2];

    // Offset plus signed projected value, clamped to the screen range.
    function automatic logic signed [SW-1:0] screen_val(
        input logic signed [15:0] ofs,
        input logic               neg,
        input logic               ovf,
        input logic [QW-1:0]      q,
        input logic               inexact
    );
        logic [QW:0]          mag;
        logic signed [SW-1:0] prj;
        logic signed [SW-1:0] s;
        mag = ovf ? {1'b0, 1'b1, {(QW-1){1'b0}}} : {1'b0, q};
        if (neg) begin
            prj = -$signed(SW'(mag)) - SW'(inexact && !ovf);
        end else begin
            prj = $signed(SW'(mag));
        end
        s = {{(SW-20){ofs[15]}}, ofs, 4'b0} + prj;
        if (s < vtp_pkg::SCR_MIN) begin
            s = vtp_pkg::SCR_MIN;
        end else if (s > vtp_pkg::SCR_MAX) begin
            s = vtp_pkg::SCR_MAX;
        end
        return s;
    endfunction

    assign w_adv = !(r_ov && i_stall);
    assign o_pop = w_adv && i_valid;

    assign w_in_ax[0] = i_job.ax_x;
    assign w_in_ax[1] = i_job.ax_y;
    assign w_num[0]   = {{(RW-vtp_pkg::MAG_W-4){1'b0}}, i_job.ax_x.mag, 4'b0};
    assign w_num[1]   = {{(RW-vtp_pkg::MAG_W-4){1'b0}}, i_job.ax_y.mag, 4'b0};

    // Stage 0 flags quotients too large for the divider; stage s then
    // settles quotient bit QW-s by one compare and subtract.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= QW; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_den[0] <= i_job.den;
            r_dep[0] <= i_job.depth;
            for (int a = 0; a < 2; a++) begin
                r_rem[a][0] <= w_num[a];
                r_q[a][0]   <= '0;
                r_ovf[a][0] <= w_num[a] >= (RW'(i_job.den) << QW);
                r_neg[a][0] <= w_in_ax[a].neg;
                r_ofs[a][0] <= w_in_ax[a].ofs;
            end
            for (int s = 1; s <= QW; s++) begin
                r_den[s] <= r_den[s-1];
                r_dep[s] <= r_dep[s-1];
                for (int a = 0; a < 2; a++) begin
                    r_ovf[a][s] <= r_ovf[a][s-1];
                    r_neg[a][s] <= r_neg[a][s-1];
                    r_ofs[a][s] <= r_ofs[a][s-1];
                    if (r_rem[a][s-1] >= (RW'(r_den[s-1]) << (QW - s))) begin
                        r_rem[a][s] <= r_rem[a][s-1] - (RW'(r_den[s-1]) << (QW - s));
                        r_q[a][s]   <= r_q[a][s-1] | (QW'(1) << (QW - s));
                    end else begin
                        r_rem[a][s] <= r_rem[a][s-1];
                        r_q[a][s]   <= r_q[a][s-1];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_scr[a] = screen_val(r_ofs[a][QW], r_neg[a][QW], r_ovf[a][QW],
                                  r_q[a][QW], r_rem[a][QW] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_vld[QW];
        end
        if (w_adv) begin
            r_sx <= w_scr[0][vtp_pkg::SCR_W-1:0];
            r_sy <= w_scr[1][vtp_pkg::SCR_W-1:0];
            r_dp <= r_dep[QW];
        end
    end

    assign o_valid      = r_ov;
    assign o_screen_x   = r_sx;
    assign o_screen_y   = r_sy;
    assign o_view_depth = r_dp;

endmodule

### hw/rtl/vertex_transform_project.sv
`timescale 1ns / 1ps

// Vertex transform and perspective projection. Each input beat is one
// model-space vertex; each output beat is its screen x and y in signed 11.4
// fixed point, clamped to [-1024, 1023], plus the clamped integer view depth.
// The block accepts one vertex per clock while o_in_stall is low and
// delivers one result per clock when the output is not stalled. With no
// output stall, a result passes through three front stages (rotation
// products, row sums with the near-plane clamp, and the multiply by the
// projection distance), the queue storage when the queue is empty,
// 23 stages of the pipelined divider (an overflow check, then one quotient
// bit per stage), and the output register. An output stall freezes the
// divider and holds the result; the queue then absorbs the vertices still
// coming out of the front. The front reserves a queue entry for every
// accepted vertex, so o_in_stall rises only when the queue plus the front
// pipeline hold QUEUE_DEPTH vertices. Configuration writes are always ready
// and are meant to happen only while no vertex is in flight.

module vertex_transform_project #(
    parameter int QUEUE_DEPTH = vtp_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [vtp_pkg::COORD_W-1:0]  i_model_x,
    input  logic signed [vtp_pkg::COORD_W-1:0]  i_model_y,
    input  logic signed [vtp_pkg::COORD_W-1:0]  i_model_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [vtp_pkg::SCR_W-1:0]    o_screen_x,
    output logic signed [vtp_pkg::SCR_W-1:0]    o_screen_y,
    output logic [vtp_pkg::DEPTH_W-1:0]         o_view_depth,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic          w_accept;
    logic          w_full;
    logic          w_push;
    vtp_pkg::t_job w_front_job;
    logic          w_q_valid;
    vtp_pkg::t_job w_q_job;
    logic          w_pop;

    // A vertex beat is taken whenever the queue has an unreserved entry.
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;
    assign o_cfg_ready = 1'b1;

    vtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_model_x   (i_model_x),
        .i_model_y   (i_model_y),
        .i_model_z   (i_model_z),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    vtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (w_accept),
        .i_push    (w_push),
        .i_job     (w_front_job),
        .i_pop     (w_pop),
        .o_full    (w_full),
        .o_valid   (w_q_valid),
        .o_job     (w_q_job)
    );

    vtp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_job        (w_q_job),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_view_depth (o_view_depth)
    );

endmodule

### dv/tb_vertex_transform_project.sv
`timescale 1ns / 1ps

// Self-checking bench for the vertex transform and projection block.
// Vertices go in through the stall handshake, results come back in order,
// and every result beat is compared against a typed expectation or a
// shadow transform model tracking the registers written via the config port.
module tb_vertex_transform_project;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;      // a little more than the pipeline latency
    localparam int PHASE_BEATS   = 150;
    localparam int NUM_PHASES    = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam longint QUOT_CAP  = 131072;
    localparam longint SCR_LO    = -16384;
    localparam longint SCR_HI    = 16368;

    typedef struct {
        logic signed [vtp_pkg::SCR_W-1:0] sx;
        logic signed [vtp_pkg::SCR_W-1:0] sy;
        logic [vtp_pkg::DEPTH_W-1:0]      depth;
    } t_screen_beat;

    // One directed vertex. When known is set the expected beat is the one
    // typed into the row; otherwise the shadow model supplies it.
    typedef struct {
        logic signed [vtp_pkg::COORD_W-1:0] x;
        logic signed [vtp_pkg::COORD_W-1:0] y;
        logic signed [vtp_pkg::COORD_W-1:0] z;
        bit                                 known;
        int                                 sx;
        int                                 sy;
        longint                             depth;
    } t_vertex_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic signed [vtp_pkg::COORD_W-1:0]   i_model_x;
    logic signed [vtp_pkg::COORD_W-1:0]   i_model_y;
    logic signed [vtp_pkg::COORD_W-1:0]   i_model_z;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic signed [vtp_pkg::SCR_W-1:0]     o_screen_x;
    logic signed [vtp_pkg::SCR_W-1:0]     o_screen_y;
    logic [vtp_pkg::DEPTH_W-1:0]          o_view_depth;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [vtp_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [vtp_pkg::CFG_DATA_W-1:0]       i_cfg_data;

    vertex_transform_project dut (.*);

    // Shadow copy of the configuration registers, reset values included.
    logic [47:0] rot_row [3];
    logic [31:0] trans [3];
    logic [15:0] proj_dist;
    logic [31:0] scr_offset;

    t_screen_beat pending_beats[$];
    int  error_count;
    int  cycle_count;
    bit  hold_off_req;
    int  zero_gap_run;

    // With the reset configuration the view position equals the vertex, the
    // near plane sits at 128 and H is 256, so these rows can be worked by hand.
    t_vertex_row reset_rows[5] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 0,      0,      128},
        '{16'sd100,    -16'sd100,   16'sd256,    1'b1, 1600,   -1600,  256},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b1, 4096,   4096,   32767},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, -16384, -16384, 128},
        '{16'sd32767,  -16'sd32768, 16'sd0,      1'b1, 16368,  -16384, 128}
    };

    // Rows run after the huge-translation setup below. Negative and small
    // depths land on the fractional near plane, and the large translation
    // drives the quotient into its cap.
    t_vertex_row corner_rows[8] = '{
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b0, 0, 0, 0},
        '{16'sd1,      -16'sd1,     16'sd128,    1'b0, 0, 0, 0},
        '{-16'sd32768, 16'sd32767,  16'sd32767,  1'b0, 0, 0, 0},
        '{16'sd32767,  -16'sd32768, 16'sd1,      1'b0, 0, 0, 0},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, 0, 0, 0},
        '{16'sd21845,  -16'sd21846, 16'sd2,      1'b0, 0, 0, 0},
        '{-16'sd21846, 16'sd21845,  16'sd200,    1'b0, 0, 0, 0},
        '{16'sd3,      16'sd5,      16'sd7,      1'b0, 0, 0, 0}
    };

    always #2 i_clk = ~i_clk;

    // Rotation row dotted with the vertex, plus the translation, in .12 units.
    function automatic longint view_axis(logic [47:0] row, longint mx, longint my,
                                         longint mz, logic [31:0] t);
        return longint'($signed(row[15:0])) * mx + longint'($signed(row[31:16])) * my
             + longint'($signed(row[47:32])) * mz + longint'($signed(t)) * 4096;
    endfunction

    // Offset plus floor(v * h * 16 / d), with the integer quotient capped,
    // then clamped to the 11.4 screen range.
    function automatic logic [vtp_pkg::SCR_W-1:0] screen_axis(logic [15:0] ofs,
                                                              longint v,
                                                              longint h, longint d);
        longint n, a, q, r, frac, mag, s;
        bit     neg, rem;
        n    = v * h;
        neg  = n < 0;
        a    = neg ? -n : n;
        q    = a / d;
        r    = a % d;
        frac = (r * 16) / d;
        rem  = ((r * 16) % d) != 0;
        if (q > QUOT_CAP) begin
            q    = QUOT_CAP;
            frac = 0;
            rem  = 0;
        end
        mag = q * 16 + frac;
        s   = longint'($signed(ofs)) * 16 + (neg ? -mag - longint'(rem) : mag);
        if (s < SCR_LO) s = SCR_LO;
        if (s > SCR_HI) s = SCR_HI;
        return s[vtp_pkg::SCR_W-1:0];
    endfunction

    function automatic t_screen_beat project_vertex(logic signed [15:0] mx,
                                                    logic signed [15:0] my,
                                                    logic signed [15:0] mz);
        t_screen_beat b;
        longint vx, vy, vz, h, nearp, d, dint;
        vx = view_axis(rot_row[0], mx, my, mz, trans[0]);
        vy = view_axis(rot_row[1], mx, my, mz, trans[1]);
        vz = view_axis(rot_row[2], mx, my, mz, trans[2]);
        h  = (proj_dist == 0) ? 1 : longint'(proj_dist);
        nearp = h * 2048;
        if (nearp < 4096) nearp = 4096;
        d = (vz < nearp) ? nearp : vz;
        b.sx = screen_axis(scr_offset[15:0], vx, h, d);
        b.sy = screen_axis(scr_offset[31:16], vy, h, d);
        dint = d / 4096;
        if (dint > 64'sd2147483647) dint = 64'sd2147483647;
        b.depth = dint[vtp_pkg::DEPTH_W-1:0];
        return b;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(vtp_pkg::t_reg_idx idx, logic [47:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            vtp_pkg::REG_ROT0:    rot_row[0] = data;
            vtp_pkg::REG_ROT1:    rot_row[1] = data;
            vtp_pkg::REG_ROT2:    rot_row[2] = data;
            vtp_pkg::REG_TRANS_X: trans[0]   = data[31:0];
            vtp_pkg::REG_TRANS_Y: trans[1]   = data[31:0];
            vtp_pkg::REG_TRANS_Z: trans[2]   = data[31:0];
            vtp_pkg::REG_PROJ:    proj_dist  = data[15:0];
            vtp_pkg::REG_OFFSET:  scr_offset = data[31:0];
            default: ;
        endcase
    endtask

    // Registers may only change with nothing in flight.
    task automatic drain();
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int draw_gap();
        if (zero_gap_run > 0) begin
            zero_gap_run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) zero_gap_run = $urandom_range(10, 40);
        return $urandom_range(0, 6);
    endfunction

    // Offers one vertex and returns at the edge where it is accepted. The
    // expected beat is queued at that edge, from the current shadow registers.
    task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, bit known, t_screen_beat typed);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_model_x  <= x;
        i_model_y  <= y;
        i_model_z  <= z;
        do @(posedge i_clk); while (o_in_stall);
        pending_beats.push_back(known ? typed : project_vertex(x, y, z));
    endtask

    // Typed expectations only hold under the configuration they were worked
    // out for; with use_typed clear every row goes through the shadow model.
    task automatic run_rows(t_vertex_row rows[], bit use_typed);
        t_screen_beat typed;
        foreach (rows[i]) begin
            typed.sx    = rows[i].sx;
            typed.sy    = rows[i].sy;
            typed.depth = rows[i].depth;
            send_vertex(rows[i].x, rows[i].y, rows[i].z, rows[i].known && use_typed,
                        typed);
        end
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [47:0] rand_row(bit tame);
        logic [15:0] e [3];
        foreach (e[i])
            e[i] = tame ? 16'($urandom_range(0, 8192) - 4096) : 16'($urandom);
        return {e[2], e[1], e[0]};
    endfunction

    function automatic logic [47:0] extreme_row();
        logic [15:0] picks [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h1000};
        return {picks[$urandom_range(0, 3)], picks[$urandom_range(0, 3)],
                picks[$urandom_range(0, 3)]};
    endfunction

    function automatic logic [31:0] extreme_word();
        logic [31:0] picks [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        return picks[$urandom_range(0, 3)];
    endfunction

    // Phase setup. Mode 0 is a plausible camera: small rotations, the scene
    // pushed in front of the near plane, so projections rarely saturate.
    // Mode 1 is raw random, mode 2 picks corner values for every register.
    task automatic configure(int mode);
        logic [15:0] h_picks [4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0002};
        logic [31:0] ofs;
        case (mode)
            0: begin
                write_reg(vtp_pkg::REG_ROT0, rand_row(1));
                write_reg(vtp_pkg::REG_ROT1, rand_row(1));
                write_reg(vtp_pkg::REG_ROT2, rand_row(1));
                write_reg(vtp_pkg::REG_TRANS_X,
                          48'(32'($urandom_range(0, 4000) - 2000)));
                write_reg(vtp_pkg::REG_TRANS_Y,
                          48'(32'($urandom_range(0, 4000) - 2000)));
                write_reg(vtp_pkg::REG_TRANS_Z, 48'($urandom_range(500, 6000)));
                write_reg(vtp_pkg::REG_PROJ, 48'($urandom_range(1, 1024)));
                ofs = {16'($urandom_range(0, 1024) - 512),
                       16'($urandom_range(0, 1024) - 512)};
                write_reg(vtp_pkg::REG_OFFSET, 48'(ofs));
            end
            1: begin
                write_reg(vtp_pkg::REG_ROT0, rand_row(0));
                write_reg(vtp_pkg::REG_ROT1, rand_row(0));
                write_reg(vtp_pkg::REG_ROT2, rand_row(0));
                write_reg(vtp_pkg::REG_TRANS_X, 48'({$urandom, $urandom}));
                write_reg(vtp_pkg::REG_TRANS_Y, 48'({$urandom, $urandom}));
                write_reg(vtp_pkg::REG_TRANS_Z, 48'({$urandom, $urandom}));
                write_reg(vtp_pkg::REG_PROJ, 48'({$urandom, $urandom}));
                write_reg(vtp_pkg::REG_OFFSET, 48'({$urandom, $urandom}));
            end
            default: begin
                write_reg(vtp_pkg::REG_ROT0, extreme_row());
                write_reg(vtp_pkg::REG_ROT1, extreme_row());
                write_reg(vtp_pkg::REG_ROT2, extreme_row());
                write_reg(vtp_pkg::REG_TRANS_X, 48'(extreme_word()));
                write_reg(vtp_pkg::REG_TRANS_Y, 48'(extreme_word()));
                write_reg(vtp_pkg::REG_TRANS_Z, 48'(extreme_word()));
                write_reg(vtp_pkg::REG_PROJ, 48'(h_picks[$urandom_range(0, 3)]));
                write_reg(vtp_pkg::REG_OFFSET, 48'(extreme_word()));
            end
        endcase
    endtask

    // Result checker: every accepted beat is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_screen_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_beats.size() == 0) begin
                report("unexpected beat, screen_x", o_screen_x, 0);
            end else begin
                want = pending_beats.pop_front();
                if (o_screen_x !== want.sx) report("screen_x", o_screen_x, want.sx);
                if (o_screen_y !== want.sy) report("screen_y", o_screen_y, want.sy);
                if (o_view_depth !== want.depth)
                    report("view_depth", o_view_depth, want.depth);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout waiting for the block");
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: a random stall before each beat, and once a long hold-off so
    // the internal queue fills and the input side has to stall.
    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = draw_gap();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Stimulus: directed corners first, then randomized phases.
    initial begin
        t_screen_beat none;
        logic signed [15:0] vx, vy, vz;
        int modes [NUM_PHASES] = '{0, 1, 0, 2, 0, 1};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_model_x = '0;
        i_model_y = '0;
        i_model_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vtp_pkg::REG_ROT0;
        i_cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_req = 1'b0;
        zero_gap_run = 0;
        none = '{default: '0};
        rot_row[0] = 48'd4096;
        rot_row[1] = 48'd4096 << 16;
        rot_row[2] = 48'd4096 << 32;
        trans = '{default: '0};
        proj_dist = 16'd256;
        scr_offset = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_rows(reset_rows, 1'b1);
        drain();

        // Odd H gives a near plane with a half, and a translation far beyond
        // the screen forces the quotient into its cap on both axes.
        write_reg(vtp_pkg::REG_PROJ, 48'd257);
        write_reg(vtp_pkg::REG_TRANS_X, 48'h0000_7FFF_FFFF);
        write_reg(vtp_pkg::REG_TRANS_Y, 48'h0000_8000_0000);
        write_reg(vtp_pkg::REG_OFFSET, 48'h0000_8000_7FFF);
        run_rows(corner_rows, 1'b1);
        drain();

        // Maximum depth translation with the strongest z column overflows
        // the 31-bit depth; H of zero behaves as one.
        write_reg(vtp_pkg::REG_ROT2, 48'h7FFF_7FFF_7FFF);
        write_reg(vtp_pkg::REG_TRANS_Z, 48'h0000_7FFF_FFFF);
        write_reg(vtp_pkg::REG_PROJ, 48'd0);
        write_reg(vtp_pkg::REG_TRANS_X, 48'd0);
        write_reg(vtp_pkg::REG_OFFSET, 48'h0000_7FFF_8000);
        run_rows(reset_rows, 1'b0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(modes[p]);
            if (p == 2) hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (modes[p] == 0 && $urandom_range(0, 99) < 85) begin
                    vx = 16'($urandom_range(0, 4000) - 2000);
                    vy = 16'($urandom_range(0, 4000) - 2000);
                    vz = 16'($urandom_range(0, 4000) - 2000);
                end else begin
                    vx = 16'($urandom);
                    vy = 16'($urandom);
                    vz = 16'($urandom);
                end
                send_vertex(vx, vy, vz, 1'b0, none);
            end
            i_in_valid <= 1'b0;
            drain();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
